[src/pcs_pkg.sv]
package pcs_pkg;

   localparam int PEER_SLOTS = 16;
   localparam int IDX_W      = $clog2(PEER_SLOTS);
   localparam int CNT_W      = $clog2(PEER_SLOTS + 1);
   localparam int SLOT_W     = 4;
   localparam int RATE_W     = 32;
   localparam int MAXUP_W    = 8;
   localparam int CMP_W      = (CNT_W > MAXUP_W) ? CNT_W : MAXUP_W;
   localparam logic [MAXUP_W-1:0] MAXUP_RESET = 8'd4;

   typedef enum logic [1:0] {
      CMD_UPDATE  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_BALANCE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SCAN_SLOW     = 2'd0,
      SCAN_FAST_INT = 2'd1,
      SCAN_FAST_ANY = 2'd2
   } scan_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BAL,
      S_BSCAN,
      S_BAPPLY,
      S_TICK,
      S_TSCAN1,
      S_TCHK1,
      S_TSCAN2,
      S_TCHK2,
      S_TAPPLY,
      S_FIN
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     scan_start;
      scan_type scan_kind;
      logic     scan_step;
      logic     save_slow;
      logic     rec_valid;
      logic     rec_from_slow;
      logic     push_last;
   } dp_cmd_type;

   typedef struct packed {
      logic    req_valid;
      cmd_type req_cmd;
      logic    free_pos;
      logic    free_neg;
      logic    scan_last;
      logic    best_valid;
      logic    can_record;
      logic    pend_valid;
      logic    out_free;
   } dp_stat_type;

endpackage

[src/pcs_if.sv]
interface pcs_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [pcs_pkg::SLOT_W-1:0] slot;
   logic [pcs_pkg::RATE_W-1:0] rate;
   logic                      interested;

   modport source (output valid, cmd, slot, rate, interested, input ready);
   modport sink   (input valid, cmd, slot, rate, interested, output ready);
endinterface

interface pcs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pcs_pkg::SLOT_W-1:0] peer_slot;
   logic                      choke;
   logic                      last;

   modport source (output valid, peer_slot, choke, last, input ready);
   modport sink   (input valid, peer_slot, choke, last, output ready);
endinterface

interface pcs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pcs_pkg::MAXUP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[src/pcs_datapath.sv]
module pcs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   pcs_req_if.sink              req_bus,
   pcs_rsp_if.source            rsp_bus,
   pcs_csr_if.sink              csr_bus,
   input  pcs_pkg::dp_cmd_type  ctl,
   output pcs_pkg::dp_stat_type stat
);

   logic [pcs_pkg::PEER_SLOTS-1:0] present_ff, present_in;
   logic [pcs_pkg::PEER_SLOTS-1:0] choked_ff, choked_in;
   logic [pcs_pkg::PEER_SLOTS-1:0] interest_ff, interest_in;
   logic [pcs_pkg::RATE_W-1:0]     rate_ff [pcs_pkg::PEER_SLOTS];
   logic [pcs_pkg::RATE_W-1:0]     rate_in;
   logic [pcs_pkg::MAXUP_W-1:0]    max_up_ff, max_up_in;
   logic [pcs_pkg::CNT_W-1:0]      used_ff, used_in;

   logic [pcs_pkg::IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [pcs_pkg::IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [pcs_pkg::IDX_W-1:0]      slow_idx_ff, slow_idx_in;
   logic [pcs_pkg::IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   pcs_pkg::scan_type              kind_ff, kind_in;
   logic                           best_valid_ff, best_valid_in;
   logic [pcs_pkg::RATE_W-1:0]     best_rate_ff, best_rate_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           pend_choke_ff, pend_choke_in;
   logic                           out_valid_ff, out_valid_in;
   logic [pcs_pkg::SLOT_W-1:0]     out_slot_ff, out_slot_in;
   logic                           out_choke_ff, out_choke_in;
   logic                           out_last_ff, out_last_in;

   logic                           accept;
   logic                           slot_ok;
   logic [pcs_pkg::IDX_W-1:0]      req_idx;
   logic                           wr_upd, wr_rem;
   logic [pcs_pkg::IDX_W-1:0]      rec_idx;
   logic                           rec_choke;
   logic [pcs_pkg::RATE_W-1:0]     cur_rate;
   logic                           cand, better;
   logic                           out_free;

   assign accept  = ctl.accept & req_bus.valid;
   assign req_idx = pcs_pkg::IDX_W'(req_bus.slot);
   assign slot_ok = 32'(req_bus.slot) < 32'(pcs_pkg::PEER_SLOTS);
   assign wr_upd  = accept && (pcs_pkg::cmd_type'(req_bus.cmd) == pcs_pkg::CMD_UPDATE) && slot_ok;
   assign wr_rem  = accept && (pcs_pkg::cmd_type'(req_bus.cmd) == pcs_pkg::CMD_REMOVE) && slot_ok;
   assign rate_in = req_bus.rate;

   assign rec_idx   = ctl.rec_from_slow ? slow_idx_ff : best_idx_ff;
   assign rec_choke = ctl.rec_from_slow | (kind_ff == pcs_pkg::SCAN_SLOW);
   assign out_free  = !out_valid_ff || rsp_bus.ready;

   assign req_bus.ready = ctl.accept;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.peer_slot = out_slot_ff;
   assign rsp_bus.choke     = out_choke_ff;
   assign rsp_bus.last      = out_last_ff;

   assign stat.req_valid  = req_bus.valid;
   assign stat.req_cmd    = pcs_pkg::cmd_type'(req_bus.cmd);
   assign stat.free_pos   = pcs_pkg::CMP_W'(max_up_ff) > pcs_pkg::CMP_W'(used_ff);
   assign stat.free_neg   = pcs_pkg::CMP_W'(max_up_ff) < pcs_pkg::CMP_W'(used_ff);
   assign stat.scan_last  = scan_idx_ff == pcs_pkg::IDX_W'(pcs_pkg::PEER_SLOTS - 1);
   assign stat.best_valid = best_valid_ff;
   assign stat.can_record = !pend_valid_ff || out_free;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   // slot table flags and unchoked count
   always_comb begin
      present_in  = present_ff;
      choked_in   = choked_ff;
      interest_in = interest_ff;
      used_in     = used_ff;
      if (wr_upd) begin
         present_in[req_idx]  = 1'b1;
         choked_in[req_idx]   = choked_ff[req_idx] | !present_ff[req_idx];
         interest_in[req_idx] = req_bus.interested;
      end
      if (wr_rem) begin
         present_in[req_idx]  = 1'b0;
         choked_in[req_idx]   = 1'b1;
         interest_in[req_idx] = 1'b0;
         if (present_ff[req_idx] && !choked_ff[req_idx]) begin
            used_in = used_ff - pcs_pkg::CNT_W'(1);
         end
      end
      if (ctl.rec_valid) begin
         choked_in[rec_idx] = rec_choke;
         if (rec_choke) begin
            used_in = used_ff - pcs_pkg::CNT_W'(1);
         end else begin
            used_in = used_ff + pcs_pkg::CNT_W'(1);
         end
      end
   end

   assign max_up_in = csr_bus.valid ? csr_bus.data : max_up_ff;

   // one table entry per cycle; strict compares keep the lower slot on ties
   assign cur_rate = rate_ff[scan_idx_ff];

   always_comb begin
      unique case (kind_ff)
         pcs_pkg::SCAN_SLOW: begin
            cand   = present_ff[scan_idx_ff] & !choked_ff[scan_idx_ff];
            better = !best_valid_ff || (cur_rate < best_rate_ff);
         end
         pcs_pkg::SCAN_FAST_INT: begin
            cand   = present_ff[scan_idx_ff] & choked_ff[scan_idx_ff]
                     & interest_ff[scan_idx_ff];
            better = !best_valid_ff || (cur_rate > best_rate_ff);
         end
         pcs_pkg::SCAN_FAST_ANY: begin
            cand   = present_ff[scan_idx_ff] & choked_ff[scan_idx_ff];
            better = !best_valid_ff || (cur_rate > best_rate_ff);
         end
         default: begin
            cand   = 1'b0;
            better = 1'b0;
         end
      endcase
   end

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      best_idx_in   = best_idx_ff;
      best_valid_in = best_valid_ff;
      best_rate_in  = best_rate_ff;
      kind_in       = kind_ff;
      slow_idx_in   = slow_idx_ff;
      if (ctl.scan_start) begin
         scan_idx_in   = '0;
         best_valid_in = 1'b0;
         kind_in       = ctl.scan_kind;
      end else if (ctl.scan_step) begin
         scan_idx_in = scan_idx_ff + pcs_pkg::IDX_W'(1);
         if (cand && better) begin
            best_idx_in   = scan_idx_ff;
            best_rate_in  = cur_rate;
            best_valid_in = 1'b1;
         end
      end
      if (ctl.save_slow) begin
         slow_idx_in = best_idx_ff;
      end
   end

   // one change is held back so the last flag is known when it goes out
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_choke_in = pend_choke_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_slot_in   = out_slot_ff;
      out_choke_in  = out_choke_ff;
      out_last_in   = out_last_ff;
      if (ctl.rec_valid) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_slot_in  = pcs_pkg::SLOT_W'(pend_idx_ff);
            out_choke_in = pend_choke_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_idx_in   = rec_idx;
         pend_choke_in = rec_choke;
      end else if (ctl.push_last) begin
         out_valid_in  = 1'b1;
         out_slot_in   = pcs_pkg::SLOT_W'(pend_idx_ff);
         out_choke_in  = pend_choke_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         choked_ff     <= '1;
         interest_ff   <= '0;
         max_up_ff     <= pcs_pkg::MAXUP_RESET;
         used_ff       <= '0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         present_ff    <= present_in;
         choked_ff     <= choked_in;
         interest_ff   <= interest_in;
         max_up_ff     <= max_up_in;
         used_ff       <= used_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      best_idx_ff  <= best_idx_in;
      best_rate_ff <= best_rate_in;
      kind_ff      <= kind_in;
      slow_idx_ff  <= slow_idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_choke_ff <= pend_choke_in;
      out_slot_ff  <= out_slot_in;
      out_choke_ff <= out_choke_in;
      out_last_ff  <= out_last_in;
      if (wr_upd) begin
         rate_ff[req_idx] <= rate_in;
      end
   end

endmodule

[src/pcs_controller.sv]
module pcs_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  pcs_pkg::dp_stat_type stat,
   output pcs_pkg::dp_cmd_type  ctl
);

   pcs_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcs_pkg::S_IDLE: begin
            if (stat.req_valid) begin
               unique case (stat.req_cmd)
                  pcs_pkg::CMD_UPDATE:  state_in = pcs_pkg::S_IDLE;
                  pcs_pkg::CMD_REMOVE:  state_in = pcs_pkg::S_BAL;
                  pcs_pkg::CMD_TICK:    state_in = pcs_pkg::S_TICK;
                  pcs_pkg::CMD_BALANCE: state_in = pcs_pkg::S_BAL;
                  default:              state_in = pcs_pkg::S_IDLE;
               endcase
            end
         end
         pcs_pkg::S_BAL: begin
            if (stat.free_pos || stat.free_neg) begin
               state_in = pcs_pkg::S_BSCAN;
            end else begin
               state_in = pcs_pkg::S_FIN;
            end
         end
         pcs_pkg::S_BSCAN: begin
            if (stat.scan_last) state_in = pcs_pkg::S_BAPPLY;
         end
         pcs_pkg::S_BAPPLY: begin
            if (!stat.best_valid) begin
               state_in = pcs_pkg::S_FIN;
            end else if (stat.can_record) begin
               state_in = pcs_pkg::S_BAL;
            end
         end
         pcs_pkg::S_TICK: begin
            state_in = stat.free_pos ? pcs_pkg::S_FIN : pcs_pkg::S_TSCAN1;
         end
         pcs_pkg::S_TSCAN1: begin
            if (stat.scan_last) state_in = pcs_pkg::S_TCHK1;
         end
         pcs_pkg::S_TCHK1: begin
            state_in = stat.best_valid ? pcs_pkg::S_TSCAN2 : pcs_pkg::S_FIN;
         end
         pcs_pkg::S_TSCAN2: begin
            if (stat.scan_last) state_in = pcs_pkg::S_TCHK2;
         end
         pcs_pkg::S_TCHK2: begin
            if (!stat.best_valid) begin
               state_in = pcs_pkg::S_FIN;
            end else if (stat.can_record) begin
               state_in = pcs_pkg::S_TAPPLY;
            end
         end
         pcs_pkg::S_TAPPLY: begin
            if (stat.can_record) state_in = pcs_pkg::S_FIN;
         end
         pcs_pkg::S_FIN: begin
            if (!stat.pend_valid || stat.out_free) state_in = pcs_pkg::S_IDLE;
         end
         default: state_in = pcs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.scan_kind = pcs_pkg::SCAN_SLOW;
      unique case (state_ff)
         pcs_pkg::S_IDLE: ctl.accept = 1'b1;
         pcs_pkg::S_BAL: begin
            ctl.scan_start = stat.free_pos || stat.free_neg;
            ctl.scan_kind  = stat.free_pos ? pcs_pkg::SCAN_FAST_INT : pcs_pkg::SCAN_SLOW;
         end
         pcs_pkg::S_BSCAN:  ctl.scan_step = 1'b1;
         pcs_pkg::S_BAPPLY: ctl.rec_valid = stat.best_valid && stat.can_record;
         pcs_pkg::S_TICK:   ctl.scan_start = !stat.free_pos;
         pcs_pkg::S_TSCAN1: ctl.scan_step = 1'b1;
         pcs_pkg::S_TCHK1: begin
            ctl.save_slow  = stat.best_valid;
            ctl.scan_start = stat.best_valid;
            ctl.scan_kind  = pcs_pkg::SCAN_FAST_ANY;
         end
         pcs_pkg::S_TSCAN2: ctl.scan_step = 1'b1;
         pcs_pkg::S_TCHK2: begin
            ctl.rec_valid     = stat.best_valid && stat.can_record;
            ctl.rec_from_slow = 1'b1;
         end
         pcs_pkg::S_TAPPLY: ctl.rec_valid = stat.can_record;
         pcs_pkg::S_FIN:    ctl.push_last = stat.pend_valid && stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/peer_choke_scheduler.sv]
// Choke scheduler over a table of PEER_SLOTS peer slots. A req word updates a
// slot (no rsp words), removes a slot and rebalances, rebalances, or runs a
// choke-cycle tick; each rsp word is one choke change, with last set on the
// final change of that req. Peer selection walks the slot table one entry
// per clock, so each pick is a walk over all PEER_SLOTS slots: a rebalance
// walks once per change made and once more if it stops with no candidate, a
// tick walks up to twice, an update not at all. One req is worked on at a
// time; rsp words sit in a held-back register and an output register, so a
// slow consumer only stalls the walk when both are full and a further change
// is ready. Write max_uploads on the csr port only while no req is in progress.
module peer_choke_scheduler (
   input logic       clock,
   input logic       reset,
   pcs_req_if.sink   req_bus,
   pcs_rsp_if.source rsp_bus,
   pcs_csr_if.sink   csr_bus
);

   pcs_pkg::dp_cmd_type  ctl;
   pcs_pkg::dp_stat_type stat;

   pcs_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   pcs_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .ctl     (ctl),
      .stat    (stat)
   );

endmodule

[verif/peer_choke_scheduler_tb.sv]
`timescale 1ns / 100ps

module peer_choke_scheduler_tb;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 80;   // covers a tick walk with no change
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 48;
   localparam int MAX_PRINTED  = 100;

   typedef struct packed {
      logic [pcs_pkg::SLOT_W-1:0] peer_slot;
      logic                       choke;
      logic                       last;
   } choke_change_type;

   // Mirror of the peer table; predicts the choke changes of each request.
   class choke_scoreboard;
      bit                          present [pcs_pkg::PEER_SLOTS];
      bit                          choked  [pcs_pkg::PEER_SLOTS];
      bit                          wants   [pcs_pkg::PEER_SLOTS];
      logic [pcs_pkg::RATE_W-1:0]  rates   [pcs_pkg::PEER_SLOTS];
      logic [pcs_pkg::MAXUP_W-1:0] max_uploads;
      choke_change_type            expected_q[$];

      function new();
         for (int i = 0; i < pcs_pkg::PEER_SLOTS; i++) begin
            present[i] = 1'b0;
            choked[i]  = 1'b1;
            wants[i]   = 1'b0;
            rates[i]   = '0;
         end
         max_uploads = pcs_pkg::MAXUP_RESET;
      endfunction

      function void set_max_uploads(logic [pcs_pkg::MAXUP_W-1:0] value);
         max_uploads = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int free_uploads();
         int used;
         used = 0;
         for (int i = 0; i < pcs_pkg::PEER_SLOTS; i++)
            if (present[i] && !choked[i])
               used++;
         return int'(max_uploads) - used;
      endfunction

      // ties keep the lower slot: only a strictly better rate replaces
      function int slowest_unchoked();
         int pick;
         pick = -1;
         for (int i = 0; i < pcs_pkg::PEER_SLOTS; i++)
            if (present[i] && !choked[i])
               if (pick < 0 || rates[i] < rates[pick])
                  pick = i;
         return pick;
      endfunction

      function int fastest_choked(bit need_interest);
         int pick;
         pick = -1;
         for (int i = 0; i < pcs_pkg::PEER_SLOTS; i++)
            if (present[i] && choked[i] && (!need_interest || wants[i]))
               if (pick < 0 || rates[i] > rates[pick])
                  pick = i;
         return pick;
      endfunction

      function void push_change(int idx, bit choke);
         choke_change_type c;
         c.peer_slot = idx[pcs_pkg::SLOT_W-1:0];
         c.choke     = choke;
         c.last      = 1'b0;
         expected_q = {expected_q, c};
      endfunction

      function void balance();
         int spare;
         int pick;
         spare = free_uploads();
         while (spare > 0) begin
            pick = fastest_choked(1'b1);
            if (pick < 0)
               break;
            choked[pick] = 1'b0;
            push_change(pick, 1'b0);
            spare--;
         end
         while (spare < 0) begin
            pick = slowest_unchoked();
            if (pick < 0)
               break;
            choked[pick] = 1'b1;
            push_change(pick, 1'b1);
            spare++;
         end
      endfunction

      function void rotate();
         int slow;
         int fast;
         if (free_uploads() > 0)
            return;
         slow = slowest_unchoked();
         if (slow < 0)
            return;
         fast = fastest_choked(1'b0);
         if (fast < 0)
            return;
         choked[slow] = 1'b1;
         choked[fast] = 1'b0;
         push_change(slow, 1'b1);
         push_change(fast, 1'b0);
      endfunction

      function void note_request(pcs_pkg::cmd_type cmd, logic [pcs_pkg::SLOT_W-1:0] slot,
                                 logic [pcs_pkg::RATE_W-1:0] rate, logic interested);
         int first;
         first = expected_q.size();
         unique case (cmd)
            pcs_pkg::CMD_UPDATE: begin
               if (!present[slot]) begin
                  present[slot] = 1'b1;
                  choked[slot]  = 1'b1;
               end
               rates[slot] = rate;
               wants[slot] = interested;
            end
            pcs_pkg::CMD_REMOVE: begin
               present[slot] = 1'b0;
               choked[slot]  = 1'b1;
               wants[slot]   = 1'b0;
               rates[slot]   = '0;
               balance();
            end
            pcs_pkg::CMD_TICK:    rotate();
            pcs_pkg::CMD_BALANCE: balance();
         endcase
         if (expected_q.size() > first)
            expected_q[expected_q.size()-1].last = 1'b1;
      endfunction

      // empty string when the word matches the oldest expected change
      function string check_change(choke_change_type got);
         choke_change_type exp;
         string            msg;
         if (expected_q.size() == 0)
            return $sformatf("unexpected change slot=%0d choke=%0b last=%0b",
                             got.peer_slot, got.choke, got.last);
         exp = expected_q[0];
         expected_q.delete(0);
         msg = "";
         if (got.peer_slot !== exp.peer_slot)
            msg = {msg, $sformatf(" peer_slot got %0d exp %0d", got.peer_slot, exp.peer_slot)};
         if (got.choke !== exp.choke)
            msg = {msg, $sformatf(" choke got %0b exp %0b", got.choke, exp.choke)};
         if (got.last !== exp.last)
            msg = {msg, $sformatf(" last got %0b exp %0b", got.last, exp.last)};
         if (msg != "")
            msg = {"change mismatch:", msg};
         return msg;
      endfunction
   endclass

   logic clock;
   logic reset;

   pcs_req_if req_bus ();
   pcs_rsp_if rsp_bus ();
   pcs_csr_if csr_bus ();

   peer_choke_scheduler DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   choke_scoreboard sb;
   int  error_count;
   int  changes_checked;
   int  cmd_count [4];
   int  settings_used;
   int  stall_cycles;
   bit  quiet;

   always #CLK_HALF clock = ~clock;

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // result monitor
   always @(posedge clock) begin
      choke_change_type got;
      string            msg;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.peer_slot = rsp_bus.peer_slot;
         got.choke     = rsp_bus.choke;
         got.last      = rsp_bus.last;
         msg = sb.check_change(got);
         changes_checked++;
         if (msg != "")
            report_mismatch(msg);
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (quiet)
         rsp_bus.ready <= 1'b1;
      else
         rsp_bus.ready <= ($urandom_range(0, 99) >= 8);
   end

   // watchdog: no word moving on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAIL peer_choke_scheduler");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(pcs_pkg::cmd_type cmd, logic [pcs_pkg::SLOT_W-1:0] slot,
                               logic [pcs_pkg::RATE_W-1:0] rate, logic interested);
      req_bus.cmd        <= cmd;
      req_bus.slot       <= slot;
      req_bus.rate       <= rate;
      req_bus.interested <= interested;
      req_bus.valid      <= 1'b1;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sb.note_request(cmd, slot, rate, interested);
      cmd_count[cmd]++;
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 99) < 8) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_max_uploads(logic [pcs_pkg::MAXUP_W-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      sb.set_max_uploads(value);
      settings_used++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_request();
      int                         pick;
      pcs_pkg::cmd_type           cmd;
      logic [pcs_pkg::RATE_W-1:0] rate;
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = pcs_pkg::CMD_UPDATE;
      else if (pick < 57) cmd = pcs_pkg::CMD_REMOVE;
      else if (pick < 80) cmd = pcs_pkg::CMD_TICK;
      else                cmd = pcs_pkg::CMD_BALANCE;
      // small rates make ties common
      pick = $urandom_range(0, 9);
      if (pick < 4)       rate = $urandom_range(0, 3);
      else if (pick < 8)  rate = $urandom;
      else if (pick == 8) rate = '0;
      else                rate = '1;
      maybe_gap();
      send_request(cmd, pcs_pkg::SLOT_W'($urandom_range(0, pcs_pkg::PEER_SLOTS-1)), rate,
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      logic [pcs_pkg::MAXUP_W-1:0] phase_uploads [10];
      phase_uploads = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd255, 8'd16, 8'd15, 8'd0, 8'd6, 8'd4};
      phase_uploads[7] = pcs_pkg::MAXUP_W'($urandom_range(0, 255));

      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      quiet = 1'b0;
      error_count = 0;
      changes_checked = 0;
      settings_used = 0;
      stall_cycles = 0;
      cmd_count = '{0, 0, 0, 0};
      req_bus.valid = 1'b0;
      req_bus.cmd = pcs_pkg::CMD_UPDATE;
      req_bus.slot = '0;
      req_bus.rate = '0;
      req_bus.interested = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, ties, tick swap, rewrite and removal of live peers
      write_max_uploads(8'd4);
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);
      send_request(pcs_pkg::CMD_BALANCE, 4'd0, '0, 1'b0);
      send_request(pcs_pkg::CMD_REMOVE,  4'd7, '0, 1'b0);
      send_request(pcs_pkg::CMD_UPDATE,  4'd0,  32'd0, 1'b1);
      send_request(pcs_pkg::CMD_UPDATE,  4'd15, '1, 1'b1);
      send_request(pcs_pkg::CMD_UPDATE,  4'd3,  32'd1000, 1'b0);
      send_request(pcs_pkg::CMD_UPDATE,  4'd5,  32'd1000, 1'b1);
      send_request(pcs_pkg::CMD_UPDATE,  4'd9,  32'd1000, 1'b1);
      send_request(pcs_pkg::CMD_UPDATE,  4'd12, 32'd500, 1'b1);
      send_request(pcs_pkg::CMD_UPDATE,  4'd1,  32'd1000, 1'b1);
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);       // slots free: no swap
      send_request(pcs_pkg::CMD_BALANCE, 4'd0, '0, 1'b0);
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);       // unchokes an uninterested peer
      send_request(pcs_pkg::CMD_UPDATE,  4'd5,  32'd7, 1'b0);   // live peer keeps its state
      send_request(pcs_pkg::CMD_REMOVE,  4'd15, '0, 1'b0);
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);
      wait_drained();
      write_max_uploads(8'd0);
      send_request(pcs_pkg::CMD_BALANCE, 4'd0, '0, 1'b0);       // chokes everyone, slowest first
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);       // nobody unchoked
      wait_drained();
      write_max_uploads(8'd255);
      send_request(pcs_pkg::CMD_UPDATE,  4'd2,  32'hAAAA_5555, 1'b1);
      send_request(pcs_pkg::CMD_REMOVE,  4'd0, '0, 1'b0);
      send_request(pcs_pkg::CMD_TICK,    4'd0, '0, 1'b0);
      send_request(pcs_pkg::CMD_UPDATE,  4'd14, 32'h5555_AAAA, 1'b0);
      send_request(pcs_pkg::CMD_BALANCE, 4'd0, '0, 1'b0);
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         quiet = (p == 3);
         write_max_uploads(phase_uploads[p]);
         for (int k = 0; k < PHASE_ITEMS; k++)
            random_request();
         wait_drained();
      end
      quiet = 1'b0;

      $display("covered %0d updates, %0d removes, %0d ticks, %0d balances",
               cmd_count[pcs_pkg::CMD_UPDATE], cmd_count[pcs_pkg::CMD_REMOVE],
               cmd_count[pcs_pkg::CMD_TICK], cmd_count[pcs_pkg::CMD_BALANCE]);
      $display("checked %0d choke changes over %0d max_uploads settings, %0d mismatches",
               changes_checked, settings_used, error_count);
      if (error_count == 0)
         $display("PASS peer_choke_scheduler");
      else
         $display("FAIL peer_choke_scheduler");
      $finish;
   end

endmodule

[peer_choke_scheduler.f]
src/pcs_pkg.sv
src/pcs_if.sv
src/pcs_datapath.sv
src/pcs_controller.sv
src/peer_choke_scheduler.sv
verif/peer_choke_scheduler_tb.sv
